[rtl/igfr_pkg.sv]
// igfr_pkg: shared types and constants of the idle gap frame receiver
`default_nettype none

package igfr_pkg;

    localparam int unsigned STORE_DEPTH_DEF = 4096;
    localparam int unsigned TIMEOUT_W = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd217;
    localparam int unsigned LEN_W = 13;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INIT  = 2'd0,
        ST_IDLE  = 2'd1,
        ST_RCV   = 2'd2,
        ST_ERROR = 2'd3
    } t_rx_state;

    typedef struct packed {
        logic      frame_ready;
        logic      byte_dropped;
        logic      overflow_event;
        t_rx_state rx_state;
    } t_step_flags;

endpackage

`default_nettype wire

[rtl/igfr_if.sv]
// igfr_if: request and response channel interfaces
`default_nettype none

interface igfr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [11:0] read_index;

    modport source (output valid, command, rx_byte, read_index, input ready);
    modport sink (input valid, command, rx_byte, read_index, output ready);
endinterface

interface igfr_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        frame_ready;
    logic [12:0] frame_length;
    logic        byte_dropped;
    logic        overflow_event;
    logic [1:0]  receiver_state;

    modport source (output valid, read_data, frame_ready, frame_length, byte_dropped,
                    overflow_event, receiver_state, input ready);
    modport sink (input valid, read_data, frame_ready, frame_length, byte_dropped,
                  overflow_event, receiver_state, output ready);
endinterface

`default_nettype wire

[rtl/igfr_store.sv]
// igfr_store: frame byte store, one write and one registered read port
`default_nettype none

module igfr_store #(
    parameter int unsigned DEPTH = igfr_pkg::STORE_DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]        i_wr_addr,
    input  wire [igfr_pkg::BYTE_W-1:0]     i_wr_data,
    input  wire                            i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]        i_rd_addr,
    output logic [igfr_pkg::BYTE_W-1:0]    o_rd_data
);

    logic [igfr_pkg::BYTE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/igfr_ctrl.sv]
// igfr_ctrl: receive state machine, gap timer and store address control
`default_nettype none

module igfr_ctrl #(
    parameter int unsigned DEPTH = igfr_pkg::STORE_DEPTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_accept,
    input  wire [1:0]                         i_command,
    input  wire [igfr_pkg::BYTE_W-1:0]        i_rx_byte,
    input  wire [igfr_pkg::INDEX_W-1:0]       i_read_index,
    input  wire                               i_cfg_we,
    input  wire [igfr_pkg::TIMEOUT_W-1:0]     i_cfg_data,
    output logic                              o_wr_en,
    output logic [$clog2(DEPTH)-1:0]          o_wr_addr,
    output logic [igfr_pkg::BYTE_W-1:0]       o_wr_data,
    output logic                              o_rd_en,
    output logic [$clog2(DEPTH)-1:0]          o_rd_addr,
    output logic                              o_rd_ok,
    output igfr_pkg::t_step_flags             o_flags,
    output logic [igfr_pkg::LEN_W-1:0]        o_frame_length
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned WPW = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (WPW > igfr_pkg::INDEX_W) ? WPW : igfr_pkg::INDEX_W;
    localparam int unsigned TW = igfr_pkg::TIMEOUT_W;

    igfr_pkg::t_rx_state r_state, n_state;
    logic [WPW-1:0]      r_wpos, n_wpos;
    logic [TW-1:0]       r_count, n_count;
    logic                r_run, n_run;
    logic                r_waiting, n_waiting;
    logic [TW-1:0]       r_timeout, n_timeout;
    logic [TW-1:0]       w_count_inc;
    logic [CMPW-1:0]     w_idx_ext;
    igfr_pkg::t_cmd      w_cmd;

    assign w_cmd = igfr_pkg::t_cmd'(i_command);
    assign w_count_inc = r_count + TW'(1);
    assign w_idx_ext = CMPW'(i_read_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= igfr_pkg::ST_INIT;
            r_wpos    <= '0;
            r_count   <= '0;
            r_run     <= 1'b1;
            r_waiting <= 1'b0;
            r_timeout <= igfr_pkg::TIMEOUT_RST;
        end else begin
            r_state   <= n_state;
            r_wpos    <= n_wpos;
            r_count   <= n_count;
            r_run     <= n_run;
            r_waiting <= n_waiting;
            r_timeout <= n_timeout;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_wpos    = r_wpos;
        n_count   = r_count;
        n_run     = r_run;
        n_waiting = r_waiting;
        n_timeout = r_timeout;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_wpos);
        o_wr_data = i_rx_byte;
        o_flags.byte_dropped   = 1'b0;
        o_flags.overflow_event = 1'b0;

        if (i_cfg_we) begin
            // timeout write also restarts reception from init
            n_timeout = i_cfg_data;
            n_state   = igfr_pkg::ST_INIT;
            n_count   = '0;
            n_run     = 1'b1;
        end else if (i_accept) begin
            unique case (w_cmd)
                igfr_pkg::CMD_BYTE: begin
                    if (r_waiting) begin
                        o_flags.byte_dropped = 1'b1;
                    end else begin
                        n_count = '0;
                        n_run   = 1'b1;
                        unique case (r_state)
                            igfr_pkg::ST_IDLE: begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = '0;
                                n_wpos    = WPW'(1);
                                n_state   = igfr_pkg::ST_RCV;
                            end
                            igfr_pkg::ST_RCV: begin
                                if (r_wpos < WPW'(DEPTH)) begin
                                    o_wr_en = 1'b1;
                                    n_wpos  = r_wpos + WPW'(1);
                                end else begin
                                    n_wpos  = '0;
                                    n_state = igfr_pkg::ST_IDLE;
                                    o_flags.overflow_event = 1'b1;
                                end
                            end
                            default: begin
                                // init and error discard the byte
                            end
                        endcase
                    end
                end
                igfr_pkg::CMD_TICK: begin
                    if (r_run) begin
                        if (w_count_inc >= r_timeout) begin
                            if (r_state == igfr_pkg::ST_RCV) begin
                                n_waiting = 1'b1;
                            end
                            n_run   = 1'b0;
                            n_count = '0;
                            n_state = igfr_pkg::ST_IDLE;
                        end else begin
                            n_count = w_count_inc;
                        end
                    end
                end
                igfr_pkg::CMD_READ: begin
                end
                igfr_pkg::CMD_RELEASE: begin
                    if (r_waiting) begin
                        n_waiting = 1'b0;
                        n_wpos    = '0;
                        n_state   = igfr_pkg::ST_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end

        o_flags.frame_ready = n_waiting;
        o_flags.rx_state    = n_state;
        o_frame_length      = igfr_pkg::LEN_W'(n_wpos);
    end

    assign o_rd_en   = i_accept && !i_cfg_we && (w_cmd == igfr_pkg::CMD_READ);
    assign o_rd_addr = AW'(i_read_index);
    assign o_rd_ok   = o_rd_en && (w_idx_ext < CMPW'(r_wpos))
                       && (w_idx_ext < CMPW'(DEPTH));

endmodule

`default_nettype wire

[rtl/idle_gap_frame_receiver.sv]
// idle_gap_frame_receiver: top level, request pipeline and response register
//
// Splits a received byte stream into frames at quiet gaps measured in timer
// ticks. Each request (byte, tick, read, release) yields one response. One
// request is taken every cycle while responses are not stalled; a response
// is built from the registered read of the frame store, then held in the
// response register. Reception state and the gap timer are flops;
// frame bytes live in a single-port-write, single-port-read memory whose
// contents are defined only below the current frame length. Write the gap
// timeout only while no request is in flight; the write restarts reception.
`default_nettype none

module idle_gap_frame_receiver #(
    parameter int unsigned STORE_DEPTH = igfr_pkg::STORE_DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    igfr_req_if.sink                       i_req,
    igfr_rsp_if.source                     o_rsp,
    input  wire                            i_cfg_we,
    input  wire [igfr_pkg::TIMEOUT_W-1:0]  i_cfg_data
);

    localparam int unsigned AW = $clog2(STORE_DEPTH);

    logic                            w_accept;
    logic                            w_s1_adv;
    logic                            w_wr_en;
    logic [AW-1:0]                   w_wr_addr;
    logic [igfr_pkg::BYTE_W-1:0]     w_wr_data;
    logic                            w_rd_en;
    logic [AW-1:0]                   w_rd_addr;
    logic                            w_rd_ok;
    logic [igfr_pkg::BYTE_W-1:0]     w_rd_data;
    igfr_pkg::t_step_flags           w_flags;
    logic [igfr_pkg::LEN_W-1:0]      w_len;

    logic                            r_s1_valid;
    logic                            r_s1_rd_ok;
    igfr_pkg::t_step_flags           r_s1_flags;
    logic [igfr_pkg::LEN_W-1:0]      r_s1_len;

    logic                            r_o_valid;
    logic [igfr_pkg::BYTE_W-1:0]     r_o_data;
    igfr_pkg::t_step_flags           r_o_flags;
    logic [igfr_pkg::LEN_W-1:0]      r_o_len;

    // stage one may move on when the response register is free or draining
    assign w_s1_adv    = !r_o_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || w_s1_adv;
    assign w_accept    = i_req.valid && i_req.ready;

    igfr_ctrl #(
        .DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_command      (i_req.command),
        .i_rx_byte      (i_req.rx_byte),
        .i_read_index   (i_req.read_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .o_rd_ok        (w_rd_ok),
        .o_flags        (w_flags),
        .o_frame_length (w_len)
    );

    igfr_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_rd_ok <= w_rd_ok;
            r_s1_flags <= w_flags;
            r_s1_len   <= w_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_o_data  <= r_s1_rd_ok ? w_rd_data : '0;
            r_o_flags <= r_s1_flags;
            r_o_len   <= r_s1_len;
        end
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.read_data      = r_o_data;
    assign o_rsp.frame_ready    = r_o_flags.frame_ready;
    assign o_rsp.frame_length   = r_o_len;
    assign o_rsp.byte_dropped   = r_o_flags.byte_dropped;
    assign o_rsp.overflow_event = r_o_flags.overflow_event;
    assign o_rsp.receiver_state = r_o_flags.rx_state;

`ifndef NO_ASSERTIONS
    a_drop_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.byte_dropped) |-> o_rsp.frame_ready)
        else $error("byte dropped without a waiting frame");

    a_overflow_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.overflow_event) |->
        (o_rsp.receiver_state == igfr_pkg::ST_IDLE && o_rsp.frame_length == '0))
        else $error("overflow did not return reception to idle");

    a_read_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> $stable(w_rd_data))
        else $error("store read data changed while stage one stalled");

    a_drop_excl_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.byte_dropped && o_rsp.overflow_event))
        else $error("byte both dropped and overflowed");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking testbench of the idle gap frame receiver
`default_nettype none

module tb_top;
    import igfr_pkg::*;

    localparam int unsigned DEPTH = STORE_DEPTH_DEF;
    localparam int unsigned WDOG_LIMIT = 2000;
    localparam int unsigned RAND_ITEMS_PER_PHASE = 265;
    localparam int unsigned MAX_PRINTED = 100;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        frame_ready;
        logic [12:0] frame_length;
        logic        byte_dropped;
        logic        overflow_event;
        t_rx_state   rx_state;
    } rsp_t;

    typedef struct {
        bit          is_cfg;
        logic [15:0] cfg_val;
        t_cmd        cmd;
        logic [7:0]  rx_byte;
        logic [11:0] idx;
        bit          typed;
        rsp_t        want;
    } dir_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [TIMEOUT_W-1:0] cfg_data;

    igfr_req_if req_bus ();
    igfr_rsp_if rsp_bus ();

    idle_gap_frame_receiver i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    logic [15:0] m_timeout;
    t_rx_state   m_state;
    logic [12:0] m_pos;
    logic [15:0] m_count;
    logic        m_running;
    logic        m_waiting;
    logic [7:0]  m_store [DEPTH];

    rsp_t expected_rsp [$];
    bit   cur_typed;
    rsp_t cur_want;

    int send_idle_pct;
    int rsp_stall_pct;
    int err_count;
    int idle_cycles;
    int sent_items;

    function automatic rsp_t frame_rx_step(t_cmd cmd, logic [7:0] b, logic [11:0] idx);
        rsp_t r;
        r = '0;
        case (cmd)
            CMD_BYTE: begin
                if (m_waiting) begin
                    r.byte_dropped = 1'b1;
                end else if (m_state == ST_IDLE) begin
                    m_store[0] = b;
                    m_pos = 13'd1;
                    m_state = ST_RCV;
                    m_count = '0;
                    m_running = 1'b1;
                end else if (m_state == ST_RCV) begin
                    if (m_pos < DEPTH) begin
                        m_store[m_pos[11:0]] = b;
                        m_pos = m_pos + 13'd1;
                    end else begin
                        // store full: drop the frame and start over
                        m_pos = '0;
                        m_state = ST_IDLE;
                        r.overflow_event = 1'b1;
                    end
                    m_count = '0;
                    m_running = 1'b1;
                end else begin
                    m_count = '0;
                    m_running = 1'b1;
                end
            end
            CMD_TICK: begin
                if (m_running) begin
                    m_count = m_count + 16'd1;
                    if (m_count >= m_timeout) begin
                        if (m_state == ST_RCV) m_waiting = 1'b1;
                        m_running = 1'b0;
                        m_count = '0;
                        m_state = ST_IDLE;
                    end
                end
            end
            CMD_READ: begin
                if (idx < m_pos) r.read_data = m_store[idx];
            end
            default: begin
                if (m_waiting) begin
                    m_waiting = 1'b0;
                    m_pos = '0;
                    m_state = ST_IDLE;
                end
            end
        endcase
        r.frame_ready = m_waiting;
        r.frame_length = m_pos;
        r.rx_state = m_state;
        return r;
    endfunction

    task automatic report_error(string msg);
        if (err_count < MAX_PRINTED) $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        rsp_t w;
        if (!i_rst_n) begin
            m_timeout = TIMEOUT_RST;
            m_state = ST_INIT;
            m_pos = '0;
            m_count = '0;
            m_running = 1'b1;
            m_waiting = 1'b0;
            idle_cycles = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                w = frame_rx_step(t_cmd'(req_bus.command), req_bus.rx_byte, req_bus.read_index);
                expected_rsp.push_back(cur_typed ? cur_want : w);
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_rsp.size() == 0) begin
                    report_error("response with no request pending");
                end else begin
                    w = expected_rsp.pop_front();
                    check_field("read_data", 16'(rsp_bus.read_data), 16'(w.read_data));
                    check_field("frame_ready", 16'(rsp_bus.frame_ready), 16'(w.frame_ready));
                    check_field("frame_length", 16'(rsp_bus.frame_length),
                                16'(w.frame_length));
                    check_field("byte_dropped", 16'(rsp_bus.byte_dropped),
                                16'(w.byte_dropped));
                    check_field("overflow_event", 16'(rsp_bus.overflow_event),
                                16'(w.overflow_event));
                    check_field("receiver_state", 16'(rsp_bus.receiver_state),
                                16'(w.rx_state));
                end
            end
            if (cfg_we) begin
                m_timeout = cfg_data;
                m_state = ST_INIT;
                m_count = '0;
                m_running = 1'b1;
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_req(t_cmd cmd, logic [7:0] b, logic [11:0] idx, bit typed,
                            rsp_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid = 1'b1;
        req_bus.command = cmd;
        req_bus.rx_byte = b;
        req_bus.read_index = idx;
        cur_typed = typed;
        cur_want = want;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic send_plain(t_cmd cmd, logic [7:0] b, logic [11:0] idx);
        send_req(cmd, b, idx, 1'b0, '0);
    endtask

    // request with don't-care fields randomized
    task automatic send_rand(t_cmd cmd);
        send_plain(cmd, 8'($urandom), 12'($urandom));
    endtask

    task automatic drain();
        req_bus.valid = 1'b0;
        while (expected_rsp.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic ticks_to_idle();
        while (m_state != ST_IDLE) send_rand(CMD_TICK);
    endtask

    task automatic send_bytes(int n);
        repeat (n) send_plain(CMD_BYTE, 8'($urandom), 12'($urandom));
    endtask

    task automatic send_frame();
        int n;
        if (m_waiting) send_rand(CMD_RELEASE);
        if (m_state != ST_IDLE && m_state != ST_RCV) ticks_to_idle();
        n = ($urandom_range(19) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 1);
        repeat (n) begin
            send_rand(CMD_BYTE);
            // quiet stretch shorter than the gap keeps the frame open
            if (m_timeout > 1 && $urandom_range(3) == 0)
                repeat ($urandom_range(int'(m_timeout) - 1)) send_rand(CMD_TICK);
        end
        while (!m_waiting && m_state == ST_RCV) send_rand(CMD_TICK);
        repeat ($urandom_range(4, 1)) begin
            if (m_pos != 0 && $urandom_range(9) < 7)
                send_plain(CMD_READ, 8'($urandom), 12'($urandom_range(int'(m_pos) - 1)));
            else
                send_rand(CMD_READ);
        end
        if ($urandom_range(3) == 0) send_rand(CMD_BYTE);
        if ($urandom_range(9) != 0) send_rand(CMD_RELEASE);
    endtask

    function automatic dir_row_t dir_req(t_cmd cmd, logic [7:0] b, logic [11:0] idx);
        dir_row_t r;
        r = '{is_cfg: 1'b0, cfg_val: '0, cmd: cmd, rx_byte: b, idx: idx, typed: 1'b0,
              want: '0};
        return r;
    endfunction

    function automatic dir_row_t dir_cfg(logic [15:0] v);
        dir_row_t r;
        r = dir_req(CMD_BYTE, '0, '0);
        r.is_cfg = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    function automatic dir_row_t dir_chk(t_cmd cmd, logic [7:0] b, logic [11:0] idx,
                                         logic [7:0] rd, logic rdy, logic [12:0] len,
                                         logic drop, logic ovf, t_rx_state st);
        dir_row_t r;
        r = dir_req(cmd, b, idx);
        r.typed = 1'b1;
        r.want = '{rd, rdy, len, drop, ovf, st};
        return r;
    endfunction

    initial begin
        dir_row_t rows [$];
        int idle_tab [4];
        int stall_tab [4];
        idle_tab = '{0, 46, 0, 23};
        stall_tab = '{0, 0, 46, 23};
        err_count = 0;
        sent_items = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        cur_typed = 1'b0;
        cur_want = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req_bus.valid = 1'b0;
        req_bus.command = CMD_BYTE;
        req_bus.rx_byte = '0;
        req_bus.read_index = '0;
        i_rst_n = 1'b0;

        // after reset: init state, bytes only restart the timer
        rows.push_back(dir_chk(CMD_READ, 8'h00, 12'h000, 8'h00, 0, 0, 0, 0, ST_INIT));
        rows.push_back(dir_chk(CMD_BYTE, 8'hff, 12'h000, 8'h00, 0, 0, 0, 0, ST_INIT));
        rows.push_back(dir_chk(CMD_TICK, 8'h00, 12'h000, 8'h00, 0, 0, 0, 0, ST_INIT));
        rows.push_back(dir_chk(CMD_RELEASE, 8'h00, 12'h000, 8'h00, 0, 0, 0, 0, ST_INIT));
        rows.push_back(dir_cfg(16'd1));
        rows.push_back(dir_chk(CMD_TICK, 8'hff, 12'hfff, 8'h00, 0, 0, 0, 0, ST_IDLE));
        // tick with the timer stopped
        rows.push_back(dir_chk(CMD_TICK, 8'h00, 12'h000, 8'h00, 0, 0, 0, 0, ST_IDLE));
        rows.push_back(dir_chk(CMD_BYTE, 8'h00, 12'hfff, 8'h00, 0, 1, 0, 0, ST_RCV));
        rows.push_back(dir_req(CMD_BYTE, 8'hff, 12'h000));
        rows.push_back(dir_req(CMD_BYTE, 8'ha5, 12'h000));
        rows.push_back(dir_req(CMD_READ, 8'hff, 12'h000));
        rows.push_back(dir_req(CMD_READ, 8'h00, 12'h001));
        rows.push_back(dir_req(CMD_READ, 8'h00, 12'h003));
        rows.push_back(dir_chk(CMD_READ, 8'h00, 12'hfff, 8'h00, 0, 3, 0, 0, ST_RCV));
        rows.push_back(dir_chk(CMD_TICK, 8'h00, 12'h000, 8'h00, 1, 3, 0, 0, ST_IDLE));
        rows.push_back(dir_chk(CMD_BYTE, 8'h5a, 12'h000, 8'h00, 1, 3, 1, 0, ST_IDLE));
        rows.push_back(dir_req(CMD_READ, 8'h00, 12'h002));
        rows.push_back(dir_chk(CMD_RELEASE, 8'hff, 12'hfff, 8'h00, 0, 0, 0, 0, ST_IDLE));
        // zero gap behaves like a gap of one
        rows.push_back(dir_cfg(16'd0));
        rows.push_back(dir_chk(CMD_BYTE, 8'h11, 12'h000, 8'h00, 0, 0, 0, 0, ST_INIT));
        rows.push_back(dir_chk(CMD_TICK, 8'h00, 12'h000, 8'h00, 0, 0, 0, 0, ST_IDLE));
        rows.push_back(dir_req(CMD_BYTE, 8'h22, 12'h000));
        rows.push_back(dir_req(CMD_TICK, 8'h00, 12'h000));
        // timeout write with a frame waiting keeps the frame
        rows.push_back(dir_cfg(16'd3));
        rows.push_back(dir_req(CMD_READ, 8'h00, 12'h000));
        rows.push_back(dir_req(CMD_BYTE, 8'h33, 12'h000));
        rows.push_back(dir_req(CMD_RELEASE, 8'h00, 12'h000));
        rows.push_back(dir_req(CMD_BYTE, 8'h44, 12'h000));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg)
                write_timeout(rows[i].cfg_val);
            else
                send_req(rows[i].cmd, rows[i].rx_byte, rows[i].idx, rows[i].typed,
                         rows[i].want);
        end

        // longest gap keeps the timer running, then a full store and an overflow
        write_timeout(16'hffff);
        repeat (20) send_rand(CMD_TICK);
        write_timeout(16'd5);
        ticks_to_idle();
        send_bytes(DEPTH);
        send_plain(CMD_READ, 8'($urandom), 12'(DEPTH - 1));
        send_plain(CMD_READ, 8'($urandom), 12'h000);
        send_bytes(1);
        repeat (6) send_rand(CMD_READ);
        send_rand(CMD_RELEASE);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: write_timeout(16'($urandom_range(8, 2)));
                1: write_timeout(16'd1);
                2: write_timeout(16'($urandom_range(12, 3)));
                default: write_timeout(16'($urandom_range(40, 16)));
            endcase
            send_idle_pct = idle_tab[p];
            rsp_stall_pct = stall_tab[p];
            sent_items = 0;
            while (sent_items < RAND_ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 15)
                    repeat ($urandom_range(6, 1)) send_plain(t_cmd'($urandom_range(3)),
                                                             8'($urandom), 12'($urandom));
                else
                    send_frame();
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (expected_rsp.size() != 0)
            report_error($sformatf("%0d responses never arrived", expected_rsp.size()));
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
